>>> rtl/hbs_pkg.sv
// hbs_pkg: shared types and constants for the hdlc bit stuffer
// used by hbs_front, hbs_fifo, hbs_back and hdlc_bit_stuffer_top
package hbs_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned RunLimit  = 5;
    localparam int unsigned RunW      = 3;
    // one byte grows to at most ten bits: two stuffed zeros
    localparam int unsigned SegW      = 10;
    localparam int unsigned SegCntW   = $clog2(SegW + 1);
    // up to seven pending bits plus one stuffed segment
    localparam int unsigned PendMax   = 7;
    localparam int unsigned AccW      = PendMax + SegW;
    localparam int unsigned AccCntW   = $clog2(AccW + 1);
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    // one stuffed byte, bits left aligned, first bit in the msb
    typedef struct packed {
        logic [SegW-1:0]    bits;
        logic [SegCntW-1:0] nbits;
        logic               last;
    } t_hbs_seg;

endpackage

>>> rtl/hdlc_bit_stuffer_top.sv
// HDLC zero-bit insertion. Frame bytes enter msb first; after every five
// consecutive ones a zero is inserted and the stream is repacked msb first
// into output bytes, the last one of a frame zero padded and flagged with
// o_frame_done. The front stuffs a whole byte combinationally and takes a
// new byte every cycle while its four-entry queue has room. The back packer
// sends one output byte per cycle unless the output stalls, refilling from
// the queue in the same cycle, so an input byte yields one or two output bytes
// (two or three for an end byte with a partial flush); the output port sets
// the sustained rate. Any output stall backs up through the queue to o_ready.
// depends on hbs_pkg, hbs_front, hbs_fifo, hbs_back
module hdlc_bit_stuffer_top
    import hbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ByteW-1:0] i_data_byte,
    input  logic             i_end_of_frame,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ByteW-1:0] o_stuffed_byte,
    output logic             o_frame_done
);

    logic     push;
    t_hbs_seg push_seg;
    logic     queue_ready;
    logic     seg_valid;
    t_hbs_seg seg;
    logic     pop;

    hbs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_push         (push),
        .o_seg          (push_seg),
        .i_queue_ready  (queue_ready)
    );

    hbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (push_seg),
        .o_ready (queue_ready),
        .o_valid (seg_valid),
        .o_seg   (seg),
        .i_pop   (pop)
    );

    hbs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seg_valid    (seg_valid),
        .i_seg          (seg),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stuffed_byte (o_stuffed_byte),
        .o_frame_done   (o_frame_done)
    );

endmodule

>>> rtl/hbs_front.sv
// hbs_front: takes frame bytes and inserts a zero after every five ones
// depends on hbs_pkg; feeds stuffed segments into hbs_fifo
module hbs_front
    import hbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ByteW-1:0] i_data_byte,
    input  logic             i_end_of_frame,
    output logic             o_push,
    output t_hbs_seg         o_seg,
    input  logic             i_queue_ready
);

    logic [RunW-1:0] r_run;
    logic [RunW-1:0] n_run;
    logic [SegW-1:0]    v_bits;
    logic [SegCntW-1:0] v_cnt;

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;

    // walk the eight data bits msb first, the run carries across bytes
    always_comb begin
        logic [RunW-1:0] run;
        logic            bit_v;
        run    = r_run;
        v_bits = '0;
        v_cnt  = '0;
        for (int b = ByteW - 1; b >= 0; b--) begin
            bit_v  = i_data_byte[b];
            v_bits = {v_bits[SegW-2:0], bit_v};
            v_cnt  = v_cnt + SegCntW'(1);
            if (bit_v) begin
                if (run == RunW'(RunLimit - 1)) begin
                    v_bits = {v_bits[SegW-2:0], 1'b0};
                    v_cnt  = v_cnt + SegCntW'(1);
                    run    = '0;
                end else begin
                    run = run + RunW'(1);
                end
            end else begin
                run = '0;
            end
        end
        n_run = run;
    end

    always_comb begin
        o_seg.bits  = v_bits << (SegCntW'(SegW) - v_cnt);
        o_seg.nbits = v_cnt;
        o_seg.last  = i_end_of_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (o_push) begin
            r_run <= i_end_of_frame ? '0 : n_run;
        end
    end

endmodule

>>> rtl/hbs_fifo.sv
// hbs_fifo: short queue of stuffed segments between front and back
// depends on hbs_pkg
module hbs_fifo
    import hbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_hbs_seg i_seg,
    output logic     o_ready,
    output logic     o_valid,
    output t_hbs_seg o_seg,
    input  logic     i_pop
);

    t_hbs_seg               r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wr_ptr;
    logic [QueuePtrW-1:0]   r_rd_ptr;
    logic [QueueCntW-1:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_ready = (r_count != QueueCntW'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_seg   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QueuePtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QueuePtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QueueCntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QueueCntW'(1);
            end
        end
    end

endmodule

>>> rtl/hbs_back.sv
// hbs_back: packs stuffed segments into output bytes and flushes at frame end
// depends on hbs_pkg; drains hbs_fifo
module hbs_back
    import hbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_seg_valid,
    input  t_hbs_seg         i_seg,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ByteW-1:0] o_stuffed_byte,
    output logic             o_frame_done
);

    // accumulator is left aligned, bits past the count are kept zero
    logic [AccW-1:0]    r_acc;
    logic [AccCntW-1:0] r_cnt;
    logic               r_last;
    logic               r_out_valid;
    logic [ByteW-1:0]   r_out_byte;
    logic               r_out_done;

    logic [AccW-1:0]    n_acc;
    logic [AccCntW-1:0] n_cnt;
    logic               n_last;

    logic               slot_free;
    logic               have_byte;
    logic               emit;
    logic               emit_done;
    logic [AccW-1:0]    acc_e;
    logic [AccCntW-1:0] cnt_e;
    logic               last_e;

    always_comb begin
        slot_free = !r_out_valid || i_ready;
        have_byte = (r_cnt >= AccCntW'(ByteW)) || (r_last && (r_cnt != '0));
        emit      = have_byte && slot_free;
        emit_done = r_last && (r_cnt <= AccCntW'(ByteW));

        acc_e  = r_acc;
        cnt_e  = r_cnt;
        last_e = r_last;
        if (emit) begin
            acc_e = r_acc << ByteW;
            if (emit_done) begin
                cnt_e  = '0;
                last_e = 1'b0;
            end else begin
                cnt_e = r_cnt - AccCntW'(ByteW);
            end
        end

        // refill behind the byte going out this cycle
        o_pop  = i_seg_valid && (cnt_e < AccCntW'(ByteW)) && !last_e;
        n_acc  = acc_e;
        n_cnt  = cnt_e;
        n_last = last_e;
        if (o_pop) begin
            n_acc  = acc_e | ({i_seg.bits, {PendMax{1'b0}}} >> cnt_e[2:0]);
            n_cnt  = cnt_e + AccCntW'(i_seg.nbits);
            n_last = i_seg.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_last <= n_last;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= r_acc[AccW-1 -: ByteW];
            r_out_done <= emit_done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_stuffed_byte = r_out_byte;
    assign o_frame_done   = r_out_done;

endmodule

>>> tb/hbs_checker.sv
// hbs_checker: watches both channels of the hdlc bit stuffer, predicts the
// stuffed output bytes and compares every output transfer in order
// depends on hbs_pkg
`timescale 1ns / 100ps

module hbs_checker
    import hbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [ByteW-1:0] i_data_byte,
    input  logic             i_end_of_frame,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [ByteW-1:0] i_stuffed_byte,
    input  logic             i_frame_done,
    output int               o_errors,
    output int               o_outstanding
);

    typedef struct packed {
        logic [ByteW-1:0] stuffed;
        logic             done;
    } t_out_byte;

    t_out_byte     expected_out[$];
    t_out_byte     want;
    logic [6:0]    pend_bits;
    int unsigned   pend_cnt;
    int unsigned   ones_run;

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
    end

    // stuff one frame byte into the running bit stream and queue the bytes it completes
    function automatic void stuff_frame_byte(input logic [ByteW-1:0] data, input logic eof);
        logic        stream[$];
        t_out_byte   made[$];
        t_out_byte   tail;
        logic [7:0]  acc;
        int unsigned nacc;
        int unsigned run;
        run = ones_run;
        for (int b = ByteW - 1; b >= 0; b--) begin
            stream.push_back(data[b]);
            if (data[b]) begin
                run++;
                if (run == RunLimit) begin
                    stream.push_back(1'b0);
                    run = 0;
                end
            end else begin
                run = 0;
            end
        end
        acc  = {1'b0, pend_bits};
        nacc = pend_cnt;
        foreach (stream[i]) begin
            acc = {acc[6:0], stream[i]};
            nacc++;
            if (nacc == ByteW) begin
                made.push_back('{stuffed: acc, done: 1'b0});
                acc  = '0;
                nacc = 0;
            end
        end
        if (eof) begin
            if (nacc != 0) begin
                made.push_back('{stuffed: acc << (ByteW - nacc), done: 1'b1});
            end else begin
                tail = made.pop_back();
                tail.done = 1'b1;
                made.push_back(tail);
            end
            pend_bits = '0;
            pend_cnt  = 0;
            ones_run  = 0;
        end else begin
            pend_bits = acc[6:0];
            pend_cnt  = nacc;
            ones_run  = run;
        end
        foreach (made[i]) expected_out.push_back(made[i]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_out.delete();
            pend_bits = '0;
            pend_cnt  = 0;
            ones_run  = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                stuff_frame_byte(i_data_byte, i_end_of_frame);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_out.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("%0t: output byte %02h done %0b with nothing expected",
                                 $realtime, i_stuffed_byte, i_frame_done);
                    end
                end else begin
                    want = expected_out.pop_front();
                    if (want.stuffed !== i_stuffed_byte || want.done !== i_frame_done) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%0t: expected byte %02h done %0b, got byte %02h done %0b",
                                     $realtime, want.stuffed, want.done,
                                     i_stuffed_byte, i_frame_done);
                        end
                    end
                end
            end
        end
        o_outstanding = expected_out.size();
    end

endmodule

>>> tb/tb_hdlc_bit_stuffer_top.sv
// tb_hdlc_bit_stuffer_top: drives frames into the hdlc bit stuffer with random
// gaps and output stalls, and gives the verdict from the checker's counts
// depends on hbs_pkg, hdlc_bit_stuffer_top, hbs_checker
`timescale 1ns / 100ps

module tb_hdlc_bit_stuffer_top;
    import hbs_pkg::*;

    localparam int unsigned RandomItems = 500;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned TailCycles  = 20;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [ByteW-1:0] i_data_byte;
    logic             i_end_of_frame;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [ByteW-1:0] o_stuffed_byte;
    logic             o_frame_done;

    int               errors;
    int               outstanding;
    int unsigned      cycle_count = 0;
    int unsigned      items_sent;
    int unsigned      rx_gap = 0;
    logic             tx_burst = 1'b0;
    logic             rx_burst = 1'b0;

    hdlc_bit_stuffer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stuffed_byte (o_stuffed_byte),
        .o_frame_done   (o_frame_done)
    );

    hbs_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_stuffed_byte (o_stuffed_byte),
        .i_frame_done   (o_frame_done),
        .o_errors       (errors),
        .o_outstanding  (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: after each transfer stall for a random number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap  = 0;
        end else if (i_ready && o_valid) begin
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            rx_gap = rx_burst ? 0 : $urandom_range(0, 9);
            i_ready <= (rx_gap == 0);
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_ready <= (rx_gap == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // called at a rising edge; returns at the edge where the byte is taken
    task automatic send_item(input logic [ByteW-1:0] data, input logic eof);
        int unsigned gap;
        if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= data;
        i_end_of_frame <= eof;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    // biased toward long runs of ones so stuffing happens often
    function automatic logic [ByteW-1:0] pick_frame_byte();
        case ($urandom_range(0, 7))
            0:       return 8'hFF;
            1:       return 8'h00;
            2:       return 8'h7E;
            3, 4:    return ByteW'($urandom | $urandom);
            5:       return ~(ByteW'(1) << $urandom_range(0, 7));
            default: return ByteW'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_item(pick_frame_byte(), i == len - 1);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data_byte    = '0;
        i_end_of_frame = 1'b0;
        items_sent     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // whole bytes at the end, no padding byte
        send_item(8'h00, 1'b1);
        // one stuffed zero, one bit flushed
        send_item(8'hFF, 1'b1);
        // ones run carried from one byte into the next
        send_item(8'h0F, 1'b0);
        send_item(8'h80, 1'b1);
        send_item(8'h3E, 1'b1);
        send_item(8'h7E, 1'b0);
        send_item(8'h01, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        // seven pending bits and a run of four, then two stuffs and a flush
        repeat (7) send_item(8'hF8, 1'b0);
        send_item(8'h0F, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b1);
        hold_until_drained();

        items_sent = 0;
        while (items_sent < RandomItems) begin
            if ($urandom_range(0, 9) == 0) begin
                send_frame($urandom_range(7, 24));
            end else begin
                send_frame($urandom_range(1, 6));
            end
            if (items_sent >= RandomItems / 2 && items_sent < RandomItems / 2 + 8) begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (TailCycles) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
